[rtl/core/pet_pkg.sv]
// shared types and constants for the postfix expression evaluator
// used by pet_front, pet_back and postfix_expression_evaluator
`default_nettype none

package pet_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH     = 2;

  // magnitude limit in whole units, scaled by the fraction width where used
  localparam logic [63:0] LIMIT_UNITS = 64'd100000000000000;

  typedef enum logic [3:0] {
    OP_PUSH = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_OR   = 4'd5,
    OP_AND  = 4'd6,
    OP_EQ   = 4'd7,
    OP_NE   = 4'd8,
    OP_GT   = 4'd9,
    OP_GE   = 4'd10,
    OP_LT   = 4'd11,
    OP_LE   = 4'd12,
    OP_END  = 4'd13
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FAULT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_PUSH = 2'd0,
    K_OPER = 2'd1,
    K_END  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [63:0] operand_value;
  } token_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [1:0]         status;
  } result_t;

  // classified token handed from front to back
  typedef struct packed {
    kind_t              kind;
    opcode_t            opcode;
    logic signed [63:0] value;
  } q_entry_t;

endpackage

`default_nettype wire

[rtl/core/pet_front.sv]
// front end: accepts token beats, classifies them and queues them
// depends on pet_pkg
`default_nettype none

module pet_front import pet_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     token_valid,
  output logic          token_stall,
  input  wire token_t   token,
  output logic          q_valid,
  input  wire logic     q_take,
  output q_entry_t      q_entry
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  q_entry_t         fifo [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  q_entry_t         cls;
  logic             keep;
  logic             push;
  logic             pop;

  // classify; unused opcodes are dropped here
  always_comb begin
    cls.value  = token.operand_value;
    cls.opcode = opcode_t'(token.opcode);
    keep       = 1'b1;
    if (token.opcode == OP_PUSH) begin
      cls.kind = K_PUSH;
    end else if (token.opcode == OP_END) begin
      cls.kind = K_END;
    end else if (token.opcode > OP_END) begin
      cls.kind = K_OPER;
      keep     = 1'b0;
    end else begin
      cls.kind = K_OPER;
    end
  end

  assign token_stall = (count == (PW+1)'(QUEUE_DEPTH));
  assign q_valid     = (count != '0);
  assign q_entry     = fifo[rd_ptr];
  assign push        = token_valid && !token_stall && keep;
  assign pop         = q_valid && q_take;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/pet_back.sv]
// back end: operand stack memory, sequencer, multiply and divide units
// depends on pet_pkg
`default_nettype none

module pet_back import pet_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_valid,
  output logic           q_take,
  input  wire q_entry_t  q_entry,
  output logic           result_valid,
  input  wire logic      result_stall,
  output result_t        result
);

  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [63:0]        LIMIT_MAG = LIMIT_UNITS << FRAC_BITS;
  localparam logic signed [64:0] LIM_POS   = $signed({1'b0, LIMIT_MAG});
  localparam logic signed [64:0] LIM_NEG   = -LIM_POS;
  localparam logic signed [63:0] ONE_VAL   = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] TWO_VAL   = ONE_VAL <<< 1;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_RD_B    = 11'b00000000010,
    S_RD_A    = 11'b00000000100,
    S_EXEC    = 11'b00000001000,
    S_MUL     = 11'b00000010000,
    S_MUL_FIN = 11'b00000100000,
    S_DIV     = 11'b00001000000,
    S_DIV_FIN = 11'b00010000000,
    S_WB      = 11'b00100000000,
    S_END_RD  = 11'b01000000000,
    S_EMIT    = 11'b10000000000
  } state_t;

  state_t              state;
  logic [SPW-1:0]      sp;
  status_t             err;
  logic                seen;
  opcode_t             op;
  logic signed [63:0]  a;
  logic signed [63:0]  b;
  logic [63:0]         ma;
  logic [63:0]         mb;
  logic                neg;
  logic signed [63:0]  r;
  logic                ok;
  logic [5:0]          cnt;
  logic [63:0]         prod;
  logic [6:0]          prod_sh;
  logic [127:0]        acc;
  logic [63:0]         rem;
  logic [63:0]         lo;
  logic [63:0]         quo;
  logic signed [63:0]  emit_val;
  status_t             emit_st;

  logic [63:0]         stack_mem [STACK_DEPTH];
  logic [63:0]         rdata;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       waddr;
  logic [63:0]         wdata;
  logic                wen;

  logic [SPW-1:0]      sp_m1;
  logic [SPW-1:0]      sp_m2;
  logic signed [64:0]  sum;
  logic signed [64:0]  dif;
  logic signed [63:0]  simple_r;
  logic                simple_ok;
  logic [31:0]         mul_l;
  logic [31:0]         mul_r;
  logic [6:0]          mul_sh;
  logic [127:0]        mul_shifted;
  logic [63:0]         mul_m;
  logic [127:0]        dvd;
  logic [64:0]         div_t;
  logic [64:0]         div_d;
  logic                div_ge;
  logic [63:0]         ma_a;
  logic [63:0]         mb_b;

  function automatic logic is_one(input logic signed [63:0] v);
    is_one = (v >= ONE_VAL) && (v < TWO_VAL);
  endfunction

  function automatic logic [63:0] rem_sub(input logic [64:0] t, input logic [64:0] d);
    logic [64:0] s;
    s       = t - d;
    rem_sub = s[63:0];
  endfunction

  assign sp_m1 = sp - 1'b1;
  assign sp_m2 = sp - 2'd2;

  // memory port control
  always_comb begin
    raddr = sp_m1[AW-1:0];
    if (state == S_RD_B) begin
      raddr = sp_m2[AW-1:0];
    end
    waddr = sp[AW-1:0];
    wdata = (state == S_IDLE) ? q_entry.value : r;
    wen   = ((state == S_IDLE) && q_valid && (q_entry.kind == K_PUSH) &&
             (err == ST_OK) && (sp != SPW'(STACK_DEPTH))) ||
            ((state == S_WB) && ok);
  end

  assign q_take = (state == S_IDLE);

  // stack memory with registered read
  always_ff @(posedge clk) begin
    if (wen) begin
      stack_mem[waddr] <= wdata;
    end
    rdata <= stack_mem[raddr];
  end

  // combinational operators
  always_comb begin
    sum       = {a[63], a} + {b[63], b};
    dif       = {a[63], a} - {b[63], b};
    simple_ok = 1'b1;
    simple_r  = '0;
    case (op)
      OP_ADD: begin
        simple_r  = sum[63:0];
        simple_ok = (sum <= LIM_POS) && (sum >= LIM_NEG);
      end
      OP_SUB: begin
        simple_r  = dif[63:0];
        simple_ok = (dif <= LIM_POS) && (dif >= LIM_NEG);
      end
      OP_OR:   simple_r = (is_one(a) || is_one(b)) ? ONE_VAL : '0;
      OP_AND:  simple_r = (is_one(a) && is_one(b)) ? ONE_VAL : '0;
      OP_EQ:   simple_r = (a == b) ? ONE_VAL : '0;
      OP_NE:   simple_r = (a != b) ? ONE_VAL : '0;
      OP_GT:   simple_r = (a > b) ? ONE_VAL : '0;
      OP_GE:   simple_r = (a >= b) ? ONE_VAL : '0;
      OP_LT:   simple_r = (a < b) ? ONE_VAL : '0;
      default: simple_r = (a <= b) ? ONE_VAL : '0;
    endcase
  end

  // operand magnitudes
  assign ma_a = a[63] ? (64'd0 - a) : a;
  assign mb_b = b[63] ? (64'd0 - b) : b;

  // multiply partial product select, one 32x32 product per step
  always_comb begin
    case (cnt[1:0])
      2'd0: begin
        mul_l = ma[31:0];  mul_r = mb[31:0];  mul_sh = 7'd0;
      end
      2'd1: begin
        mul_l = ma[31:0];  mul_r = mb[63:32]; mul_sh = 7'd32;
      end
      2'd2: begin
        mul_l = ma[63:32]; mul_r = mb[31:0];  mul_sh = 7'd32;
      end
      default: begin
        mul_l = ma[63:32]; mul_r = mb[63:32]; mul_sh = 7'd64;
      end
    endcase
    mul_shifted = acc >> FRAC_BITS;
    mul_m       = mul_shifted[63:0];
  end

  // divider step and setup
  always_comb begin
    dvd    = {64'd0, ma_a} << FRAC_BITS;
    div_d  = {1'b0, mb};
    div_t  = {rem, lo[63]};
    div_ge = (div_t >= div_d);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sp           <= '0;
      err          <= ST_OK;
      seen         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != S_EMIT)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_entry.kind)
              K_END: begin
                emit_val <= '0;
                sp       <= '0;
                err      <= ST_OK;
                seen     <= 1'b0;
                if (err != ST_OK) begin
                  emit_st <= err;
                  state   <= S_EMIT;
                end else if (!seen || (sp == '0)) begin
                  emit_st <= ST_EMPTY;
                  state   <= S_EMIT;
                end else begin
                  emit_st <= ST_OK;
                  state   <= S_END_RD;
                end
              end
              K_PUSH: begin
                seen <= 1'b1;
                if (err == ST_OK) begin
                  if (sp == SPW'(STACK_DEPTH)) begin
                    err <= ST_FAULT;
                  end else begin
                    sp <= sp + 1'b1;
                  end
                end
              end
              default: begin
                seen <= 1'b1;
                op   <= q_entry.opcode;
                if (err == ST_OK) begin
                  if (sp < SPW'(2)) begin
                    err <= ST_FAULT;
                  end else begin
                    state <= S_RD_B;
                  end
                end
              end
            endcase
          end
        end
        S_RD_B: begin
          b     <= rdata;
          state <= S_RD_A;
        end
        S_RD_A: begin
          a     <= rdata;
          sp    <= sp_m2;
          state <= S_EXEC;
        end
        S_EXEC: begin
          ma  <= ma_a;
          mb  <= mb_b;
          neg <= a[63] ^ b[63];
          cnt <= '0;
          if (op == OP_MUL) begin
            acc   <= '0;
            state <= S_MUL;
          end else if (op == OP_DIV) begin
            rem <= dvd[127:64];
            lo  <= dvd[63:0];
            quo <= '0;
            if ((mb_b == '0) || (dvd[127:64] >= mb_b)) begin
              ok    <= 1'b0;
              state <= S_WB;
            end else begin
              state <= S_DIV;
            end
          end else begin
            r     <= simple_r;
            ok    <= simple_ok;
            state <= S_WB;
          end
        end
        S_MUL: begin
          // product of step n is accumulated at step n+1
          if (cnt != 6'd4) begin
            prod    <= mul_l * mul_r;
            prod_sh <= mul_sh;
          end
          if (cnt != '0) begin
            acc <= acc + ({64'd0, prod} << prod_sh);
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'd4) begin
            state <= S_MUL_FIN;
          end
        end
        S_MUL_FIN: begin
          ok    <= (mul_shifted[127:64] == '0) && (mul_m <= LIMIT_MAG);
          r     <= neg ? (64'd0 - mul_m) : mul_m;
          state <= S_WB;
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (div_ge) begin
            rem <= rem_sub(div_t, div_d);
          end else begin
            rem <= div_t[63:0];
          end
          quo <= {quo[62:0], div_ge};
          lo  <= {lo[62:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == 6'd63) begin
            state <= S_DIV_FIN;
          end
        end
        S_DIV_FIN: begin
          ok    <= (quo <= LIMIT_MAG);
          r     <= neg ? (64'd0 - quo) : quo;
          state <= S_WB;
        end
        S_WB: begin
          if (ok) begin
            sp <= sp + 1'b1;
          end else begin
            err <= ST_RANGE;
          end
          state <= S_IDLE;
        end
        S_END_RD: begin
          emit_val <= rdata;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (!result_valid || !result_stall) begin
            result_valid        <= 1'b1;
            result.result_value <= emit_val;
            result.status       <= emit_st;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/postfix_expression_evaluator.sv]
// postfix evaluator top: front queue feeding the stack sequencer
// per token: push writes the stack from idle; operators read b, read a, execute, write back;
// mul/div iterate first; end token reaches the output via S_END_RD (if reading) and S_EMIT;
// throughput is bounded by the back sequencer; the two-entry queue absorbs bursts
// reset clears stack pointer, error and token flags; stack contents stay undefined
// depends on pet_pkg, pet_front, pet_back
`default_nettype none

module postfix_expression_evaluator import pet_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    token_valid,
  output logic         token_stall,
  input  wire token_t  token,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  logic      q_valid;
  logic      q_take;
  q_entry_t  q_entry;

  pet_front u_front (
    .clk         (clk),
    .rst         (rst),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token       (token),
    .q_valid     (q_valid),
    .q_take      (q_take),
    .q_entry     (q_entry)
  );

  pet_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_take       (q_take),
    .q_entry      (q_entry),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

[verif/tb.sv]
// testbench for postfix_expression_evaluator: random token streams checked against
// a fixed point stack evaluator kept in a scoreboard class
// depends on pet_pkg and the evaluator rtl
`default_nettype none

module tb;
  import pet_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam logic [63:0] LIMIT_MAG = LIMIT_UNITS << FB;
  localparam logic signed [63:0] ONE = 64'sd1 <<< FB;
  localparam int CYCLE_LIMIT = 2000000;

  // expression evaluator with the queue of expected end-of-expression beats
  class expr_scoreboard;
    logic signed [63:0] stk [DEPTH];
    int sp;
    status_t err;
    bit seen;
    result_t pending [$];
    int errors;

    function new();
      sp = 0;
      err = ST_OK;
      seen = 0;
      errors = 0;
    endfunction

    function logic [63:0] mag(logic signed [63:0] v);
      return v < 0 ? -v : v;
    endfunction

    function bit is_one(logic signed [63:0] v);
      return v >= ONE && v < 2 * ONE;
    endfunction

    function logic signed [63:0] flag(bit c);
      return c ? ONE : 64'sd0;
    endfunction

    // update the stack for one accepted token beat
    function void note_token(token_t t);
      logic signed [63:0] a, b, r;
      logic signed [64:0] s;
      logic [127:0] p, n;
      logic [63:0] q;
      bit ok;
      result_t res;
      ok = 1;
      r = 0;
      if (t.opcode == OP_END) begin
        res.status = err;
        res.result_value = 0;
        if (err == ST_OK) begin
          if (!seen || sp == 0) res.status = ST_EMPTY;
          else res.result_value = stk[sp - 1];
        end
        pending.push_back(res);
        sp = 0;
        err = ST_OK;
        seen = 0;
        return;
      end
      if (t.opcode > OP_END) return;
      seen = 1;
      if (err != ST_OK) return;
      if (t.opcode == OP_PUSH) begin
        if (sp >= DEPTH) err = ST_FAULT;
        else begin
          stk[sp] = t.operand_value;
          sp++;
        end
        return;
      end
      if (sp < 2) begin
        err = ST_FAULT;
        return;
      end
      b = stk[sp - 1];
      a = stk[sp - 2];
      sp -= 2;
      case (t.opcode)
        OP_ADD, OP_SUB: begin
          s = (t.opcode == OP_ADD) ? {a[63], a} + {b[63], b} : {a[63], a} - {b[63], b};
          r = s[63:0];
          ok = (s[64] == s[63]) && mag(r) <= LIMIT_MAG;
        end
        OP_MUL: begin
          p = {64'd0, mag(a)} * {64'd0, mag(b)};
          p = p >> FB;
          ok = p[127:64] == 0 && p[63:0] <= LIMIT_MAG;
          r = ((a < 0) != (b < 0)) ? -p[63:0] : p[63:0];
        end
        OP_DIV: begin
          if (mag(b) == 0) ok = 0;
          else begin
            n = {64'd0, mag(a)} << FB;
            p = n / {64'd0, mag(b)};
            ok = p[127:64] == 0 && p[63:0] <= LIMIT_MAG;
            q = p[63:0];
            r = ((a < 0) != (b < 0)) ? -q : q;
          end
        end
        OP_OR:  r = flag(is_one(a) || is_one(b));
        OP_AND: r = flag(is_one(a) && is_one(b));
        OP_EQ:  r = flag(a == b);
        OP_NE:  r = flag(a != b);
        OP_GT:  r = flag(a > b);
        OP_GE:  r = flag(a >= b);
        OP_LT:  r = flag(a < b);
        default: r = flag(a <= b);
      endcase
      if (!ok) err = ST_RANGE;
      else begin
        stk[sp] = r;
        sp++;
      end
    endfunction

    // compare one result beat with the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected result value=%h status=%0d", $time, got.result_value,
                 got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t status mismatch expected=%0d actual=%0d", $time, want.status,
                 got.status);
        errors++;
      end
      if (got.result_value !== want.result_value) begin
        $display("%0t value mismatch expected=%h actual=%h", $time, want.result_value,
                 got.result_value);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic token_valid, token_stall;
  token_t token;
  logic result_valid, result_stall;
  result_t result;
  expr_scoreboard sb;
  int unsigned cycles = 0;
  bit hold_rx;
  bit burst_pause;

  postfix_expression_evaluator dut (
    .clk(clk), .rst(rst),
    .token_valid(token_valid), .token_stall(token_stall), .token(token),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // sample both channels at the edge
  always @(posedge clk) begin
    if (!rst && token_valid && !token_stall) sb.note_token(token);
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  // receiver stall pattern, with a forced hold-off when asked
  always @(posedge clk) begin
    if (rst) result_stall <= 0;
    else if (hold_rx) result_stall <= 1;
    else if (cycles % 4000 < 1500) result_stall <= 0;
    else result_stall <= ($urandom_range(0, 99) < 40);
  end

  // drop valid, then idle; n sets the length of the idle gap
  task automatic idle_cycles(int n);
    token_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  // send one token beat and wait for it to be taken
  task automatic send_token(opcode_t op, logic signed [63:0] v);
    if (!burst_pause && $urandom_range(0, 99) < 8) begin
      idle_cycles($urandom_range(1, 12));
    end
    token_valid <= 1;
    token <= '{opcode: op, operand_value: v};
    do @(posedge clk); while (token_stall);
  endtask

  // raw opcode variant, used for unused codes and for random 4-bit opcodes
  task automatic send_raw(logic [3:0] op, logic signed [63:0] v);
    token_valid <= 1;
    token.opcode <= op;
    token.operand_value <= v;
    do @(posedge clk); while (token_stall);
  endtask

  task automatic wait_drain();
    idle_cycles(1);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [63:0] rand_value();
    logic signed [63:0] v;
    case ($urandom_range(0, 7))
      0: v = {$urandom, $urandom};
      1: v = $signed(64'($urandom_range(0, 3))) <<< FB;
      2: v = -($signed(64'($urandom_range(0, 3))) <<< FB);
      3: v = ONE + $urandom_range(0, 65535);
      4: v = $signed({{32{1'b0}}, $urandom}) - 64'sd2147483648;
      5: v = $signed(64'($urandom_range(0, 100000))) * ONE;
      6: v = ($urandom_range(0, 1) ? 1 : -1) * $signed({16'd0, $urandom, 16'd0});
      default: v = $signed({{24{1'b0}}, $urandom, 8'd0});
    endcase
    return v;
  endfunction

  function automatic opcode_t rand_oper();
    return opcode_t'($urandom_range(OP_ADD, OP_LE));
  endfunction

  // one well formed expression of random shape
  task automatic send_expression(int n);
    int depth;
    depth = 0;
    for (int i = 0; i < n; i++) begin
      if (depth < 2 || ($urandom_range(0, 1) && depth < DEPTH)) begin
        send_token(OP_PUSH, rand_value());
        depth++;
      end else begin
        send_token(rand_oper(), rand_value());
        depth--;
      end
    end
    while (depth > 1 && $urandom_range(0, 3) != 0) begin
      send_token(rand_oper(), 0);
      depth--;
    end
    send_token(OP_END, rand_value());
  endtask

  initial begin
    int sent;
    sb = new();
    hold_rx = 0;
    burst_pause = 0;
    token_valid = 0;
    token = '0;
    rst = 1;
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: extremes, every operation, special cases
    send_token(OP_END, 0);
    send_token(OP_PUSH, 64'sh7fff_ffff_ffff_ffff);
    send_token(OP_PUSH, 64'sh8000_0000_0000_0000);
    send_token(OP_END, 0);
    for (int op = OP_ADD; op <= OP_LE; op++) begin
      send_token(OP_PUSH, 3 * ONE);
      send_token(OP_PUSH, ONE + 5);
      send_token(opcode_t'(op), 0);
      send_token(OP_END, 0);
    end
    send_token(OP_PUSH, ONE); send_token(OP_PUSH, 0);
    send_token(OP_DIV, 0); send_token(OP_ADD, 0); send_token(OP_END, 0);
    send_token(OP_PUSH, $signed(LIMIT_MAG)); send_token(OP_PUSH, ONE);
    send_token(OP_ADD, 0); send_token(OP_END, 0);
    send_token(OP_ADD, 0); send_token(OP_END, 0);
    for (int i = 0; i <= DEPTH; i++) send_token(OP_PUSH, i);
    send_token(OP_END, 0);
    send_raw(4'd14, -1); send_raw(4'd15, 0); send_token(OP_END, 0);
    send_token(OP_PUSH, -ONE); send_token(OP_PUSH, 2 * ONE - 1);
    send_token(OP_MUL, 0); send_token(OP_END, 0);

    // long receiver hold-off while tokens keep coming
    fork
      begin
        hold_rx = 1;
        repeat (400) @(posedge clk);
        hold_rx = 0;
      end
      for (int i = 0; i < 12; i++) send_expression(2);
    join

    // sender pause until everything is back
    wait_drain();

    // random part, mostly well formed with some noise
    sent = 0;
    while (sent < 1550) begin
      burst_pause = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 8) begin
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 9);
        send_expression(n);
        sent += n + 1;
      end else begin
        int k;
        k = $urandom_range(1, 5);
        for (int i = 0; i < k; i++) send_raw(4'($urandom_range(0, 15)), rand_value());
        send_token(OP_END, 0);
        sent += k + 1;
      end
      if ($urandom_range(0, 4) == 0) idle_cycles($urandom_range(1, 30));
    end
    wait_drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

`default_nettype wire
